// ----- rtl/core/cscd_pkg.sv -----
// ============================================================================
// cscd_pkg
// Shared types, codes and constants of the speed and cadence tracker.
// ============================================================================
package cscd_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_MEAS = 2'd0,
    OP_TICK = 2'd1,
    OP_DISC = 2'd2,
    OP_TAKE = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CR_START,
    ST_CR_MUL1,
    ST_CR_MUL2,
    ST_CR_DIV,
    ST_WH_START,
    ST_WH_MUL1,
    ST_WH_MUL2,
    ST_WH_DIV,
    ST_FINISH
  } state_e;

  // serial multiplier: a 32-bit multiplicand times a 16-bit multiplier
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // restoring divider width (numerator, divisor and quotient)
  localparam int unsigned DIV_W = PROD_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_STALE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAD_LIMIT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVS_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PS   = 8'd3;

  localparam logic [19:0] STALE_RST      = 20'd3000;
  localparam logic [15:0] CAD_LIMIT_RST  = 16'd2500;
  localparam logic [7:0]  REVS_LIMIT_RST = 8'd16;
  localparam logic [15:0] TICKS_PS_RST   = 16'd1024;

  // tenths of rpm per (rev per tick) / ticks-per-second, and us per second
  localparam logic [MUL_B_W-1:0] CADENCE_SCALE = 16'd600;
  localparam logic [MUL_A_W-1:0] US_PER_S      = 32'd1000000;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    op_e  op;
    logic wheel_present;
    logic crank_present;
    logic cr_first;
    logic cr_skip;
    logic wh_first;
    logic wh_skip;
    logic mul_done;
    logic div_done;
    logic out_free;
  } stat_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic dispatch;
    logic cr_start;
    logic cr_mul2;
    logic cr_div;
    logic cr_end;
    logic wh_start;
    logic wh_mul2;
    logic wh_div;
    logic wh_end;
    logic finish;
  } ctrl_t;

endpackage

// ----- rtl/core/cscd_mul.sv -----
// ============================================================================
// cscd_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ============================================================================
module cscd_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [cscd_pkg::MUL_A_W-1:0]     a_i,
  input  logic [cscd_pkg::MUL_B_W-1:0]     b_i,
  output logic [cscd_pkg::PROD_W-1:0]      prod_o,
  output logic                             done_o
);
  import cscd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] a_q;
  logic [PROD_W-1:0]  p_q, p_d;
  logic [MUL_A_W:0]   sum;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic               last;

  // add the multiplicand into the upper half, then shift right one bit
  always_comb begin
    sum  = {1'b0, p_q[PROD_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d  = {sum, p_q[MUL_B_W-1:1]};
    last = (cnt_q == CNT_W'(MUL_B_W - 1));
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign prod_o = p_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/cscd_div.sv -----
// ============================================================================
// cscd_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module cscd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cscd_pkg::DIV_W-1:0]   num_i,
  input  logic [cscd_pkg::DIV_W-1:0]   den_i,
  output logic [cscd_pkg::DIV_W-1:0]   quo_o,
  output logic                         done_o
);
  import cscd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [DIV_W:0]   trial, diff;
  logic             ge;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             last;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    last  = (cnt_q == CNT_W'(DIV_W - 1));
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: quotient bits enter where numerator bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/cscd_ctrl.sv -----
// ============================================================================
// cscd_ctrl
// Sequencer: walks one item through crank and wheel work and the result.
// ============================================================================
module cscd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cscd_pkg::stat_t stat_i,
  output cscd_pkg::ctrl_t ctrl_o
);
  import cscd_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat_i.op == OP_MEAS && stat_i.crank_present) begin
          state_d = ST_CR_START;
        end else if (stat_i.op == OP_MEAS && stat_i.wheel_present) begin
          state_d = ST_WH_START;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_CR_START: begin
        if (!stat_i.cr_first && !stat_i.cr_skip) begin
          state_d = ST_CR_MUL1;
        end else if (stat_i.wheel_present) begin
          state_d = ST_WH_START;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_CR_MUL1: begin
        if (stat_i.mul_done) state_d = ST_CR_MUL2;
      end
      ST_CR_MUL2: begin
        if (stat_i.mul_done) state_d = ST_CR_DIV;
      end
      ST_CR_DIV: begin
        if (stat_i.div_done) begin
          state_d = stat_i.wheel_present ? ST_WH_START : ST_FINISH;
        end
      end
      ST_WH_START: begin
        if (!stat_i.wh_first && !stat_i.wh_skip) begin
          state_d = ST_WH_MUL1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WH_MUL1: begin
        if (stat_i.mul_done) state_d = ST_WH_MUL2;
      end
      ST_WH_MUL2: begin
        if (stat_i.mul_done) state_d = ST_WH_DIV;
      end
      ST_WH_DIV: begin
        if (stat_i.div_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE:     ctrl_o.in_ready = 1'b1;
      ST_DISPATCH: ctrl_o.dispatch = 1'b1;
      ST_CR_START: ctrl_o.cr_start = 1'b1;
      ST_CR_MUL1:  ctrl_o.cr_mul2  = stat_i.mul_done;
      ST_CR_MUL2:  ctrl_o.cr_div   = stat_i.mul_done;
      ST_CR_DIV:   ctrl_o.cr_end   = stat_i.div_done;
      ST_WH_START: ctrl_o.wh_start = 1'b1;
      ST_WH_MUL1:  ctrl_o.wh_mul2  = stat_i.mul_done;
      ST_WH_MUL2:  ctrl_o.wh_div   = stat_i.mul_done;
      ST_WH_DIV:   ctrl_o.wh_end   = stat_i.div_done;
      ST_FINISH:   ctrl_o.finish   = stat_i.out_free;
      default:     ctrl_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/cycling_speed_cadence_tracker.sv -----
// ============================================================================
// cycling_speed_cadence_tracker
// Crank cadence and wheel interval tracking over a serial multiply/divide unit.
// ============================================================================
//
//   channel  direction  handshake                  payload
//   -------  ---------  -------------------------  ------------------------------
//   in       input      in_valid_i / in_ready_o    op, now_ms, presence, samples
//   out      output     out_valid_o / out_ready_i  cadence, deltas, ages, flags
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item passes through dispatch and finish, plus a crank pass for crank data
// that is differenced and a wheel pass for wheel data that is differenced.
// Each such sample runs two bit-serial multiplies and one restoring divide
// on the shared units. Reset sets the control, configuration and tracker
// registers at once, with no sweep; item latch, scratch and result data are
// not reset. A result waits in the output register; a stalled output holds
// the sequencer in its final state, and cfg is always ready.
//
module cycling_speed_cadence_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        op_i,
  input  logic [31:0]                       now_ms_i,
  input  logic                              wheel_present_i,
  input  logic                              crank_present_i,
  input  logic [31:0]                       wheel_revs_total_i,
  input  logic [15:0]                       wheel_event_time_i,
  input  logic [15:0]                       crank_revs_total_i,
  input  logic [15:0]                       crank_event_time_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [15:0]                       cadence_tenths_rpm_o,
  output logic                              cadence_ok_o,
  output logic [7:0]                        delta_wheel_revs_o,
  output logic [31:0]                       delta_interval_us_o,
  output logic                              speed_active_o,
  output logic [31:0]                       crank_age_ms_o,
  output logic [31:0]                       wheel_age_ms_o,
  output logic                              wheel_seen_flag_o,
  output logic                              crank_seen_flag_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cscd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cscd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cscd_pkg::*;

  stat_t stat;
  ctrl_t ctrl;

  // configuration registers
  logic [19:0] stale_q;
  logic [15:0] cad_limit_q;
  logic [7:0]  revs_limit_q;
  logic [15:0] tps_q;

  // latched item
  op_e         op_q;
  logic [31:0] now_q;
  logic        wp_q, cp_q;
  logic [31:0] wrev_q;
  logic [15:0] wtime_q, crev_q, ctime_q;

  // tracker state
  logic [15:0] prev_crank_count_q, prev_crank_stamp_q;
  logic        crank_sampled_q;
  logic [31:0] crank_event_ms_q;
  logic [15:0] cadence_value_q;
  logic        cadence_valid_q;
  logic [31:0] prev_wheel_count_q;
  logic [15:0] prev_wheel_stamp_q;
  logic        wheel_sampled_q, wheel_seen_q;
  logic [31:0] wheel_event_ms_q;
  logic [7:0]  pending_revs_q;
  logic [31:0] pending_interval_q;
  logic        wheel_flag_q, crank_flag_q;

  // scratch for the sample in flight
  logic [15:0]       crank_dt_q, wheel_dt_q;
  logic [7:0]        applied_q;
  logic [PROD_W-1:0] wheel_den_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_cad_q;
  logic        out_cad_ok_q;
  logic [7:0]  out_revs_q;
  logic [31:0] out_int_q;
  logic        out_speed_q;
  logic [31:0] out_crank_age_q, out_wheel_age_q;
  logic        out_wflag_q, out_cflag_q;

  // shared arithmetic
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  logic               mul_start, mul_done;
  logic [DIV_W-1:0]   div_den, div_quo;
  logic               div_start, div_done;

  // sample differences and ages
  logic [15:0] crank_drev, crank_dt, wheel_dt;
  logic [31:0] wheel_drev;
  logic [7:0]  wheel_applied;
  logic [31:0] crank_age, wheel_age;
  logic        cad_accept, cad_stale, speed_now;
  logic [31:0] interval_sat;
  logic        in_fire;

  assign in_fire = in_valid_i && ctrl.in_ready;

  always_comb begin
    crank_drev    = crev_q - prev_crank_count_q;
    crank_dt      = ctime_q - prev_crank_stamp_q;
    wheel_drev    = wrev_q - prev_wheel_count_q;
    wheel_dt      = wtime_q - prev_wheel_stamp_q;
    wheel_applied = (wheel_drev > {24'd0, revs_limit_q}) ? revs_limit_q : wheel_drev[7:0];
    crank_age     = now_q - crank_event_ms_q;
    wheel_age     = now_q - wheel_event_ms_q;
    cad_stale     = (crank_age >= {12'd0, stale_q});
    speed_now     = wheel_seen_q && (wheel_age < {12'd0, stale_q});
    cad_accept    = (div_quo[DIV_W-1:16] == '0) && (div_quo[15:0] != 16'd0)
                    && (div_quo[15:0] <= cad_limit_q);
    interval_sat  = (div_quo[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
  end

  // status to the sequencer
  always_comb begin
    stat.in_valid      = in_valid_i;
    stat.op            = op_q;
    stat.wheel_present = wp_q;
    stat.crank_present = cp_q;
    stat.cr_first      = !crank_sampled_q;
    stat.cr_skip       = (crank_drev == 16'd0) || (crank_dt == 16'd0);
    stat.wh_first      = !wheel_sampled_q;
    stat.wh_skip       = (wheel_drev == 32'd0) || (wheel_dt == 16'd0) || (tps_q == 16'd0);
    stat.mul_done      = mul_done;
    stat.div_done      = div_done;
    stat.out_free      = !out_valid_q || out_ready_i;
  end

  cscd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // multiplier operand select
  always_comb begin
    mul_start = (ctrl.cr_start && !stat.cr_first && !stat.cr_skip) || ctrl.cr_mul2
                || (ctrl.wh_start && !stat.wh_first && !stat.wh_skip) || ctrl.wh_mul2;
    if (ctrl.cr_start) begin
      mul_a = {16'd0, crank_drev};
      mul_b = tps_q;
    end else if (ctrl.cr_mul2) begin
      mul_a = mul_prod[MUL_A_W-1:0];
      mul_b = CADENCE_SCALE;
    end else if (ctrl.wh_start) begin
      mul_a = wheel_drev;
      mul_b = tps_q;
    end else begin
      mul_a = US_PER_S;
      mul_b = wheel_dt_q;
    end
    div_start = ctrl.cr_div || ctrl.wh_div;
    div_den   = ctrl.cr_div ? {{(DIV_W-16){1'b0}}, crank_dt_q} : wheel_den_q;
  end

  cscd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  cscd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // configuration writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q      <= STALE_RST;
      cad_limit_q  <= CAD_LIMIT_RST;
      revs_limit_q <= REVS_LIMIT_RST;
      tps_q        <= TICKS_PS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STALE:      stale_q      <= cfg_data_i;
        CFG_CAD_LIMIT:  cad_limit_q  <= cfg_data_i[15:0];
        CFG_REVS_LIMIT: revs_limit_q <= cfg_data_i[7:0];
        CFG_TICKS_PS:   tps_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // item latch and per-sample scratch
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_e'(op_i);
      now_q   <= now_ms_i;
      wp_q    <= wheel_present_i;
      cp_q    <= crank_present_i;
      wrev_q  <= wheel_revs_total_i;
      wtime_q <= wheel_event_time_i;
      crev_q  <= crank_revs_total_i;
      ctime_q <= crank_event_time_i;
    end
    if (ctrl.cr_start) crank_dt_q <= crank_dt;
    if (ctrl.wh_start) begin
      wheel_dt_q <= wheel_dt;
      applied_q  <= wheel_applied;
    end
    if (ctrl.wh_mul2) wheel_den_q <= mul_prod;
  end

  // tracker state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_crank_count_q <= '0;
      prev_crank_stamp_q <= '0;
      crank_sampled_q    <= 1'b0;
      crank_event_ms_q   <= '0;
      cadence_value_q    <= '0;
      cadence_valid_q    <= 1'b0;
      prev_wheel_count_q <= '0;
      prev_wheel_stamp_q <= '0;
      wheel_sampled_q    <= 1'b0;
      wheel_seen_q       <= 1'b0;
      wheel_event_ms_q   <= '0;
      pending_revs_q     <= '0;
      pending_interval_q <= '0;
      wheel_flag_q       <= 1'b0;
      crank_flag_q       <= 1'b0;
    end else begin
      // operation-level updates
      if (ctrl.dispatch) begin
        case (op_q)
          OP_MEAS: begin
            wheel_flag_q <= wp_q;
            crank_flag_q <= cp_q;
          end
          OP_TICK: begin
            if (cadence_valid_q && cad_stale) begin
              cadence_value_q <= '0;
              cadence_valid_q <= 1'b0;
            end
          end
          OP_DISC: begin
            crank_sampled_q    <= 1'b0;
            wheel_sampled_q    <= 1'b0;
            cadence_valid_q    <= 1'b0;
            cadence_value_q    <= '0;
            crank_flag_q       <= 1'b0;
            pending_revs_q     <= '0;
            pending_interval_q <= '0;
          end
          default: ;
        endcase
      end
      // crank sample
      if (ctrl.cr_start) begin
        prev_crank_count_q <= crev_q;
        prev_crank_stamp_q <= ctime_q;
        if (stat.cr_first) begin
          crank_sampled_q  <= 1'b1;
          crank_event_ms_q <= now_q;
        end else if (!stat.cr_skip) begin
          crank_event_ms_q <= now_q;
        end
      end
      if (ctrl.cr_end && cad_accept) begin
        cadence_value_q <= div_quo[15:0];
        cadence_valid_q <= 1'b1;
      end
      // wheel sample
      if (ctrl.wh_start) begin
        prev_wheel_count_q <= wrev_q;
        prev_wheel_stamp_q <= wtime_q;
        wheel_seen_q       <= 1'b1;
        wheel_event_ms_q   <= now_q;
        if (stat.wh_first) wheel_sampled_q <= 1'b1;
      end
      if (ctrl.wh_end && (div_quo != '0)) begin
        pending_revs_q     <= applied_q;
        pending_interval_q <= interval_sat;
      end
      // a take clears the pending delta once reported
      if (ctrl.finish && op_q == OP_TAKE) begin
        pending_revs_q     <= '0;
        pending_interval_q <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_cad_q       <= cadence_value_q;
      out_cad_ok_q    <= cadence_valid_q;
      out_revs_q      <= pending_revs_q;
      out_int_q       <= pending_interval_q;
      out_speed_q     <= speed_now;
      out_crank_age_q <= crank_sampled_q ? crank_age : 32'hFFFF_FFFF;
      out_wheel_age_q <= wheel_seen_q ? wheel_age : 32'hFFFF_FFFF;
      out_wflag_q     <= wheel_flag_q;
      out_cflag_q     <= crank_flag_q;
    end
  end

  assign in_ready_o           = ctrl.in_ready;
  assign out_valid_o          = out_valid_q;
  assign cadence_tenths_rpm_o = out_cad_q;
  assign cadence_ok_o         = out_cad_ok_q;
  assign delta_wheel_revs_o   = out_revs_q;
  assign delta_interval_us_o  = out_int_q;
  assign speed_active_o       = out_speed_q;
  assign crank_age_ms_o       = out_crank_age_q;
  assign wheel_age_ms_o       = out_wheel_age_q;
  assign wheel_seen_flag_o    = out_wflag_q;
  assign crank_seen_flag_o    = out_cflag_q;

  // an accepted item keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input open right after an accepted item");

  // an invalid cadence always reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cadence_ok_o |-> cadence_tenths_rpm_o == 16'd0)
    else $error("cadence value without valid flag");

  // pending revolutions never come without an interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delta_wheel_revs_o != 8'd0 |-> delta_interval_us_o != 32'd0)
    else $error("pending revolutions with zero interval");

  // the result register is loaded only when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before it was taken");

endmodule
